// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a rising clk edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// File: rtl/core/pwmpd_pkg.sv
// ----------------------------------------------------------------------------
// pwmpd_pkg
// Widths, constants and controller/datapath link types of the PWM meter.
// ----------------------------------------------------------------------------
package pwmpd_pkg;

  localparam int unsigned TICKS_W         = 32;
  localparam int unsigned PERIOD_W        = 33;
  localparam int unsigned DUTY_W          = 7;
  localparam int unsigned RATE_W          = 27;
  localparam int unsigned COUNT_W_DEFAULT = 32;
  localparam int unsigned EXT_W           = 64;
  localparam int unsigned DUTY_SCALE      = 100;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000000);

  // Shared restoring divider: period divides 100 * high ticks or the rate.
  localparam int unsigned DIV_NUM_W = TICKS_W + DUTY_W;
  localparam int unsigned DIV_DEN_W = PERIOD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam logic [DIV_CNT_W-1:0] DUTY_DIV_STEPS = DIV_CNT_W'(DIV_NUM_W);
  localparam logic [DIV_CNT_W-1:0] FREQ_DIV_STEPS = DIV_CNT_W'(RATE_W);

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_COUNT,
    ACT_START,
    ACT_HIGH,
    ACT_LOW
  } act_t;

  typedef enum logic {
    DIV_DUTY,
    DIV_FREQ
  } div_sel_t;

  typedef struct packed {
    act_t     act;
    logic     div_go;
    div_sel_t div_sel;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic rising;
    logic falling;
    logic div_done;
  } dp_sts_t;

endpackage

// File: rtl/core/pwmpd_in_if.sv
// ----------------------------------------------------------------------------
// pwmpd_in_if
// Tick sample channel: valid/ready with the sampled pin level.
// ----------------------------------------------------------------------------
interface pwmpd_in_if ();
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

// File: rtl/core/pwmpd_out_if.sv
// ----------------------------------------------------------------------------
// pwmpd_out_if
// Measurement result channel: valid/ready with one period's figures.
// ----------------------------------------------------------------------------
interface pwmpd_out_if import pwmpd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TICKS_W-1:0]  high_ticks;
  logic [TICKS_W-1:0]  low_ticks;
  logic [PERIOD_W-1:0] period_ticks;
  logic [DUTY_W-1:0]   duty_percent;
  logic [RATE_W-1:0]   frequency_hz;
  logic                saturated;

  modport source (output valid, output high_ticks, output low_ticks, output period_ticks,
                  output duty_percent, output frequency_hz, output saturated,
                  input ready);
  modport sink   (input valid, input high_ticks, input low_ticks, input period_ticks,
                  input duty_percent, input frequency_hz, input saturated,
                  output ready);
endinterface

// File: rtl/core/pwmpd_div.sv
// ----------------------------------------------------------------------------
// pwmpd_div
// Restoring divider, one quotient bit per cycle. The dividend is loaded
// left-aligned; steps gives the number of dividend bits to process.
// ----------------------------------------------------------------------------
module pwmpd_div import pwmpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  input  logic [DIV_CNT_W-1:0] steps,
  output logic [DIV_NUM_W-1:0] quo,
  output logic                 done
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  always_comb begin
    trial = {rem_r, num_r[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      num_nxt  = num;
      den_nxt  = den;
      quo_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_NUM_W-2:0], 1'b0};
      quo_nxt = {quo_r[DIV_NUM_W-2:0], ge};
      rem_nxt = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// File: rtl/core/pwmpd_dp.sv
// ----------------------------------------------------------------------------
// pwmpd_dp
// Datapath: edge detect, saturating phase counter, captures, result
// operands, shared divider and the output register.
// ----------------------------------------------------------------------------
module pwmpd_dp import pwmpd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_W_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [RATE_W-1:0]   cfg_wr_data,
  input  logic                in_level,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  output logic [TICKS_W-1:0]  out_high,
  output logic [TICKS_W-1:0]  out_low,
  output logic [PERIOD_W-1:0] out_period,
  output logic [DUTY_W-1:0]   out_duty,
  output logic [RATE_W-1:0]   out_freq,
  output logic                out_sat
);

  logic [RATE_W-1:0]      rate_r;
  logic                   prev_r, prev_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] hcap_r, hcap_nxt;
  logic                   hsat_r, hsat_nxt;

  logic [TICKS_W-1:0]     res_high_r, res_low_r;
  logic [PERIOD_W-1:0]    res_period_r;
  logic [DIV_NUM_W-1:0]   res_dnum_r;
  logic                   res_sat_r;
  logic [DUTY_W-1:0]      res_duty_r;
  logic [RATE_W-1:0]      res_freq_r;

  logic                   cnt_sat;
  logic [EXT_W-1:0]       cnt_ext, hcap_ext;
  logic                   hi_ovf, lo_ovf;
  logic [TICKS_W-1:0]     hi32, lo32;
  logic                   period_zero;

  logic                   div_done;
  logic [DIV_NUM_W-1:0]   div_quo;
  logic [DIV_NUM_W-1:0]   div_num;
  logic [DIV_CNT_W-1:0]   div_steps;

  assign cnt_sat  = &cnt_r;
  assign cnt_ext  = {{(EXT_W-COUNT_WIDTH){1'b0}}, cnt_r};
  assign hcap_ext = {{(EXT_W-COUNT_WIDTH){1'b0}}, hcap_r};
  assign hi_ovf   = |hcap_ext[EXT_W-1:TICKS_W];
  assign lo_ovf   = |cnt_ext[EXT_W-1:TICKS_W];
  assign hi32     = hi_ovf ? '1 : hcap_ext[TICKS_W-1:0];
  assign lo32     = lo_ovf ? '1 : cnt_ext[TICKS_W-1:0];
  assign period_zero = (res_period_r == '0);

  assign sts.rising   = in_level & ~prev_r;
  assign sts.falling  = ~in_level & prev_r;
  assign sts.div_done = div_done;

  always_comb begin
    prev_nxt = prev_r;
    cnt_nxt  = cnt_r;
    hcap_nxt = hcap_r;
    hsat_nxt = hsat_r;
    if (cmd.act != ACT_NONE) begin
      prev_nxt = in_level;
    end
    case (cmd.act)
      ACT_COUNT: begin
        if (!cnt_sat) begin
          cnt_nxt = cnt_r + COUNT_WIDTH'(1);
        end
      end
      ACT_START: begin
        cnt_nxt  = COUNT_WIDTH'(1);
        hsat_nxt = 1'b0;
      end
      ACT_HIGH: begin
        hcap_nxt = cnt_r;
        hsat_nxt = cnt_sat;
        cnt_nxt  = COUNT_WIDTH'(1);
      end
      ACT_LOW: begin
        cnt_nxt = COUNT_WIDTH'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
      prev_r <= 1'b0;
      cnt_r  <= '0;
      hcap_r <= '0;
      hsat_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rate_r <= cfg_wr_data;
      end
      prev_r <= prev_nxt;
      cnt_r  <= cnt_nxt;
      hcap_r <= hcap_nxt;
      hsat_r <= hsat_nxt;
    end
  end

  // result operands, latched on the rising edge that closes a period
  always_ff @(posedge clk) begin
    if (cmd.act == ACT_LOW) begin
      res_high_r   <= hi32;
      res_low_r    <= lo32;
      res_period_r <= {1'b0, hi32} + {1'b0, lo32};
      res_dnum_r   <= {{DUTY_W{1'b0}}, hi32} * DIV_NUM_W'(DUTY_SCALE);
      res_sat_r    <= hsat_r | cnt_sat | hi_ovf | lo_ovf;
    end
    if (div_done && cmd.div_sel == DIV_DUTY) begin
      res_duty_r <= period_zero ? '0 : div_quo[DUTY_W-1:0];
    end
    if (div_done && cmd.div_sel == DIV_FREQ) begin
      res_freq_r <= period_zero ? '0 : div_quo[RATE_W-1:0];
    end
    if (cmd.load_out) begin
      out_high   <= res_high_r;
      out_low    <= res_low_r;
      out_period <= res_period_r;
      out_duty   <= res_duty_r;
      out_freq   <= res_freq_r;
      out_sat    <= res_sat_r;
    end
  end

  assign div_num   = (cmd.div_sel == DIV_DUTY) ? res_dnum_r
                   : {rate_r, {(DIV_NUM_W-RATE_W){1'b0}}};
  assign div_steps = (cmd.div_sel == DIV_DUTY) ? DUTY_DIV_STEPS : FREQ_DIV_STEPS;

  pwmpd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .num   (div_num),
    .den   (res_period_r),
    .steps (div_steps),
    .quo   (div_quo),
    .done  (div_done)
  );

endmodule

// File: rtl/core/pwmpd_ctrl.sv
// ----------------------------------------------------------------------------
// pwmpd_ctrl
// Controller: measurement phase, divider sequencing and result handoff.
// ----------------------------------------------------------------------------
module pwmpd_ctrl import pwmpd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_WAIT,
    S_HIGH,
    S_LOW,
    S_DUTY_GO,
    S_DUTY_RUN,
    S_FREQ_GO,
    S_FREQ_RUN,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready = (state_r == S_WAIT) || (state_r == S_HIGH) || (state_r == S_LOW);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    cmd.act      = ACT_NONE;
    cmd.div_go   = 1'b0;
    cmd.div_sel  = DIV_DUTY;
    cmd.load_out = 1'b0;
    case (state_r)
      S_WAIT: begin
        if (accept) begin
          if (sts.rising) begin
            cmd.act   = ACT_START;
            state_nxt = S_HIGH;
          end else begin
            cmd.act = ACT_COUNT;
          end
        end
      end
      S_HIGH: begin
        if (accept) begin
          if (sts.falling) begin
            cmd.act   = ACT_HIGH;
            state_nxt = S_LOW;
          end else begin
            cmd.act = ACT_COUNT;
          end
        end
      end
      S_LOW: begin
        if (accept) begin
          if (sts.rising) begin
            cmd.act   = ACT_LOW;
            state_nxt = S_DUTY_GO;
          end else begin
            cmd.act = ACT_COUNT;
          end
        end
      end
      S_DUTY_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DUTY_RUN;
      end
      S_DUTY_RUN: begin
        if (sts.div_done) begin
          state_nxt = S_FREQ_GO;
        end
      end
      S_FREQ_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_FREQ;
        state_nxt   = S_FREQ_RUN;
      end
      S_FREQ_RUN: begin
        cmd.div_sel = DIV_FREQ;
        if (sts.div_done) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_HIGH;
        end
      end
      default: begin
        state_nxt = S_WAIT;
      end
    endcase

    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_CLK(a_close_stalls_input,
    (accept && state_r == S_LOW && sts.rising) |=> !in_ready,
    "period close did not stall the tick input")
  `ASSERT_CLK(a_done_in_run,
    sts.div_done |-> (state_r == S_DUTY_RUN || state_r == S_FREQ_RUN),
    "divider finished outside a run state")
  `ASSERT_NEVER(a_no_overwrite,
    cmd.load_out && out_valid_r && !out_ready,
    "pending result overwritten")
  `ASSERT_CLK(a_load_shows,
    cmd.load_out |=> out_valid_r,
    "loaded result not presented")

endmodule

// File: rtl/core/pwm_period_duty_meter_core.sv
// ----------------------------------------------------------------------------
// pwm_period_duty_meter_core
// PWM meter: high, low and period ticks, duty percent and frequency.
// ----------------------------------------------------------------------------
// in_ch carries one timer tick per transaction with the sampled pin level.
// out_ch carries one transaction per measured period, issued after the rising
// edge that closes it. cfg_wr_en/cfg_wr_data write the tick rate in Hz; write
// it only while no period result is being computed.
// Ordinary ticks are taken one per cycle. The tick that closes a period
// starts two serial divisions on one restoring divider (39 steps for duty,
// 27 for frequency); in_ready stays low until the result sits in the output
// register. The output register lets ticks flow while a result waits; a
// second result waits inside the block, holding in_ready low, until out_ch
// takes the first.
// Reset: tick rate 1000000, phase waiting for the first rising edge, level
// history and counters cleared, no result pending.
// ----------------------------------------------------------------------------
module pwm_period_duty_meter_core import pwmpd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_W_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [RATE_W-1:0] cfg_wr_data,
  pwmpd_in_if.sink          in_ch,
  pwmpd_out_if.source       out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  pwmpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  pwmpd_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_level    (in_ch.pin_level),
    .cmd         (cmd),
    .sts         (sts),
    .out_high    (out_ch.high_ticks),
    .out_low     (out_ch.low_ticks),
    .out_period  (out_ch.period_ticks),
    .out_duty    (out_ch.duty_percent),
    .out_freq    (out_ch.frequency_hz),
    .out_sat     (out_ch.saturated)
  );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives PWM pin samples into pwm_period_duty_meter_core and checks every
// period result against a cycle-free model of the meter. Stimulus covers
// directed pulse shapes, tick rate corners and random wave trains with noise
// bursts, with random stalls on both channels outside one stall-free chunk.
// ----------------------------------------------------------------------------
import pwmpd_pkg::*;

localparam int unsigned METER_COUNT_W = 17;
localparam bit [63:0]   COUNT_MAX     = (64'd1 << METER_COUNT_W) - 64'd1;
localparam bit [63:0]   FIELD32_MAX   = 64'hFFFF_FFFF;

typedef enum logic [1:0] {
  PH_WAIT,
  PH_HIGH,
  PH_LOW
} meter_phase_t;

typedef struct packed {
  logic [TICKS_W-1:0]  high_ticks;
  logic [TICKS_W-1:0]  low_ticks;
  logic [PERIOD_W-1:0] period_ticks;
  logic [DUTY_W-1:0]   duty_percent;
  logic [RATE_W-1:0]   frequency_hz;
  logic                saturated;
} period_t;

class period_scoreboard;
  meter_phase_t      phase;
  bit                prev_level;
  bit [63:0]         tick_cnt;
  bit [63:0]         high_cap;
  bit                high_sat;
  logic [RATE_W-1:0] rate;
  period_t           expected_periods[$];
  int unsigned       mismatches;
  int unsigned       ticks_seen;
  int unsigned       periods_seen;
  int unsigned       saturated_seen;

  function new();
    phase          = PH_WAIT;
    prev_level     = 1'b0;
    tick_cnt       = '0;
    high_cap       = '0;
    high_sat       = 1'b0;
    rate           = RATE_RESET;
    mismatches     = 0;
    ticks_seen     = 0;
    periods_seen   = 0;
    saturated_seen = 0;
  endfunction

  function void set_rate(logic [RATE_W-1:0] value);
    rate = value;
  endfunction

  function void take_tick(bit level);
    bit        rising;
    bit        falling;
    bit        sat;
    bit [63:0] hi;
    bit [63:0] lo;
    bit [63:0] per;
    bit [63:0] duty;
    bit [63:0] freq;
    period_t   r;
    ticks_seen++;
    rising     = level && !prev_level;
    falling    = !level && prev_level;
    prev_level = level;
    if (phase == PH_HIGH && falling) begin
      high_cap = tick_cnt;
      high_sat = (tick_cnt >= COUNT_MAX);
      tick_cnt = 64'd1;
      phase    = PH_LOW;
      return;
    end
    if (phase == PH_LOW && rising) begin
      sat = high_sat || (tick_cnt >= COUNT_MAX);
      hi  = high_cap;
      lo  = tick_cnt;
      if (hi > FIELD32_MAX) begin
        hi  = FIELD32_MAX;
        sat = 1'b1;
      end
      if (lo > FIELD32_MAX) begin
        lo  = FIELD32_MAX;
        sat = 1'b1;
      end
      per  = hi + lo;
      duty = '0;
      freq = '0;
      if (per != 0) begin
        duty = (DUTY_SCALE * hi) / per;
        freq = {37'd0, rate} / per;
      end
      r.high_ticks   = hi[TICKS_W-1:0];
      r.low_ticks    = lo[TICKS_W-1:0];
      r.period_ticks = per[PERIOD_W-1:0];
      r.duty_percent = duty[DUTY_W-1:0];
      r.frequency_hz = freq[RATE_W-1:0];
      r.saturated    = sat;
      expected_periods.push_back(r);
      tick_cnt = 64'd1;
      phase    = PH_HIGH;
      return;
    end
    if (phase != PH_HIGH && phase != PH_LOW) begin
      if (rising) begin
        tick_cnt = 64'd1;
        high_sat = 1'b0;
        phase    = PH_HIGH;
        return;
      end
      phase = PH_WAIT;
    end
    if (tick_cnt < COUNT_MAX) tick_cnt++;
  endfunction

  function bit field_differs(string name, bit [63:0] want, bit [63:0] got);
    if (want == got) return 1'b0;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1'b1;
  endfunction

  function void check_period(period_t got);
    period_t     want;
    int unsigned bad;
    if (expected_periods.size() == 0) begin
      $display("%0t ns: unexpected result transaction, expected none, actual %p",
               $time, got);
      mismatches++;
      return;
    end
    want = expected_periods.pop_front();
    bad  = 0;
    bad += field_differs("high_ticks", want.high_ticks, got.high_ticks);
    bad += field_differs("low_ticks", want.low_ticks, got.low_ticks);
    bad += field_differs("period_ticks", want.period_ticks, got.period_ticks);
    bad += field_differs("duty_percent", want.duty_percent, got.duty_percent);
    bad += field_differs("frequency_hz", want.frequency_hz, got.frequency_hz);
    bad += field_differs("saturated", want.saturated, got.saturated);
    if (bad != 0) mismatches++;
    periods_seen++;
    if (want.saturated) saturated_seen++;
  endfunction
endclass

module testbench;

  localparam int unsigned DRAIN_CYCLES   = 120;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned CHUNK_TICKS    = 350;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [RATE_W-1:0] cfg_wr_data;

  pwmpd_in_if  in_ch ();
  pwmpd_out_if out_ch ();

  pwm_period_duty_meter_core #(
    .COUNT_WIDTH (METER_COUNT_W)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  period_scoreboard sb;
  bit               gaps_on = 1'b1;
  int unsigned      sent;
  int unsigned      rate_writes;
  int unsigned      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (gaps_on) begin
      out_ch.ready <= ($urandom_range(99) >= 10);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.take_tick(in_ch.pin_level);
  end

  always @(posedge clk) begin : result_monitor
    period_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.high_ticks, out_ch.low_ticks, out_ch.period_ticks,
              out_ch.duty_percent, out_ch.frequency_hz, out_ch.saturated};
      sb.check_period(got);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("pwm_period_duty_meter_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input bit level);
    while (gaps_on && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pin_level <= level;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_pulse(input int unsigned high_n, input int unsigned low_n);
    repeat (high_n) send_tick(1'b1);
    repeat (low_n) send_tick(1'b0);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (sb.expected_periods.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_rate(value);
    rate_writes++;
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 60);
    return $urandom_range(61, 400);
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    int unsigned r;
    r = $urandom_range(3);
    if (r == 0) return RATE_W'($urandom_range(1, 1000));
    if (r == 1) return RATE_RESET;
    return RATE_W'($urandom_range(0, (1 << RATE_W) - 1));
  endfunction

  initial begin
    int unsigned target;
    sb              = new();
    sent            = 0;
    rate_writes     = 0;
    quiet_cycles    = 0;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.pin_level = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // first tick high counts as a rising edge; shortest periods and duty corners
    send_pulse(1, 1);
    send_pulse(1, 3);
    send_pulse(9, 1);
    send_pulse(2, 1);
    send_pulse(3, 4);
    send_pulse(1, 99);

    write_rate('0);
    send_pulse(4, 4);
    send_pulse(1, 1);
    write_rate({RATE_W{1'b1}});
    send_pulse(1, 1);
    send_pulse(1, 2);
    write_rate(RATE_W'(1));
    send_pulse(1, 1);
    send_pulse(2, 2);
    write_rate(RATE_W'(100000000));
    send_pulse(5, 5);

    for (int c = 0; c < 4; c++) begin
      write_rate(pick_rate());
      gaps_on = (c != 2);
      target  = sent + CHUNK_TICKS;
      while (sent < target) begin
        if ($urandom_range(99) < 85) begin
          send_pulse(pick_len(), pick_len());
        end else begin
          repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(1)));
        end
      end
    end
    gaps_on = 1'b1;

    in_ch.valid <= 1'b0;
    while (sb.expected_periods.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d ticks and %0d measured periods, %0d of them saturated,",
             sb.ticks_seen, sb.periods_seen, sb.saturated_seen);
    $display("over %0d tick rate settings including zero and the full-scale value.",
             rate_writes + 1);
    if (sb.mismatches == 0 && sb.expected_periods.size() == 0) begin
      $display("pwm_period_duty_meter_core verification clean");
    end else begin
      $display("pwm_period_duty_meter_core verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/pwmpd_pkg.sv
rtl/core/pwmpd_in_if.sv
rtl/core/pwmpd_out_if.sv
rtl/core/pwmpd_div.sv
rtl/core/pwmpd_dp.sv
rtl/core/pwmpd_ctrl.sv
rtl/core/pwm_period_duty_meter_core.sv
dv/testbench.sv
